/* rtl/core/mnp_pkg.sv */
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared constants for the MIDI note parser: status codes, reset values and
// the note-to-timer-compare table.
// ----------------------------------------------------------------------------
package mnp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DATA_W  = 7;
	localparam int unsigned PITCH_W = 16;
	localparam int unsigned NOTES   = 128;

	// status bytes
	localparam logic [BYTE_W-1:0] ST_NOTE_OFF = 8'h80;
	localparam logic [BYTE_W-1:0] ST_NOTE_ON  = 8'h90;
	localparam logic [BYTE_W-1:0] ST_SENSE    = 8'hFE;
	localparam logic [BYTE_W-1:0] ST_STOP     = 8'hFC;
	localparam logic [BYTE_W-1:0] ST_RESET    = 8'hFF;

	localparam logic [BYTE_W-1:0]  NO_NOTE     = 8'hFF;
	localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd400;

	// timer compare value per note number
	localparam logic [PITCH_W-1:0] NOTE_ROM [NOTES] = '{
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd64865, 16'd61224,
		16'd57788, 16'd54544, 16'd51483, 16'd48593, 16'd45866, 16'd43292, 16'd40862, 16'd38568,
		16'd36404, 16'd34360, 16'd32432, 16'd30612, 16'd28893, 16'd27272, 16'd25741, 16'd24296,
		16'd22933, 16'd21645, 16'd20430, 16'd19284, 16'd18201, 16'd17180, 16'd16215, 16'd15305,
		16'd14446, 16'd13635, 16'd12870, 16'd12148, 16'd11466, 16'd10822, 16'd10215, 16'd9641,
		16'd9100,  16'd8589,  16'd8107,  16'd7652,  16'd7223,  16'd6817,  16'd6435,  16'd6073,
		16'd5732,  16'd5411,  16'd5107,  16'd4820,  16'd4550,  16'd4294,  16'd4053,  16'd3826,
		16'd3611,  16'd3408,  16'd3217,  16'd3036,  16'd2866,  16'd2705,  16'd2553,  16'd2410,
		16'd2274,  16'd2147,  16'd2026,  16'd1912,  16'd1805,  16'd1704,  16'd1608,  16'd1518,
		16'd1432,  16'd1352,  16'd1276,  16'd1204,  16'd1137,  16'd1073,  16'd1013,  16'd956,
		16'd902,   16'd851,   16'd803,   16'd758,   16'd716,   16'd675,   16'd637,   16'd602,
		16'd568,   16'd536,   16'd506,   16'd477,   16'd450,   16'd425,   16'd401,   16'd379,
		16'd357,   16'd337,   16'd318,   16'd300,   16'd283,   16'd267,   16'd252,   16'd238,
		16'd225,   16'd212,   16'd200,   16'd189,   16'd178,   16'd168,   16'd159,   16'd150,
		16'd141,   16'd133,   16'd126,   16'd119,   16'd112,   16'd106,   16'd100,   16'd94,
		16'd89,    16'd84,    16'd79,    16'd74,    16'd70,    16'd66,    16'd62,    16'd59
	};

endpackage

/* rtl/core/mnp_if.sv */
// ----------------------------------------------------------------------------
// mnp_if
// Valid/ready channels of the MIDI note parser: received bytes in, note
// state out.
// ----------------------------------------------------------------------------
interface mnp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mnp_note_if;
	logic        valid;
	logic        ready;
	logic        gate;
	logic [15:0] pitch_count;
	logic        midi_active;

	modport source (output valid, output gate, output pitch_count, output midi_active,
		input ready);
	modport sink   (input valid, input gate, input pitch_count, input midi_active,
		output ready);
endinterface

/* rtl/core/midi_note_parser_unit.sv */
// ----------------------------------------------------------------------------
// midi_note_parser_unit
// Monophonic MIDI note parser: tracks gate, pitch and activity from a byte
// stream with running status.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received MIDI byte per beat (status if bit 7 is set).
//   res : one beat per input byte, carrying gate, pitch_count and
//         midi_active as they stand after that byte.
// From the rx beat to the res beat, the byte is registered, then decoded
// against the parser state, and the updated state is the result register.
// One byte is taken every cycle unless a stalled result blocks the decode
// stage; the only loop is the state update in the decode stage.
// At reset the parser is idle, the gate is on, pitch_count is 400, no note
// is held and midi_active is low.
// When the receiver stalls, the result holds, the registered byte waits in
// the decode stage and rx stays ready until that stage is occupied too.
// ----------------------------------------------------------------------------
module midi_note_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	mnp_byte_if.sink          rx,
	mnp_note_if.source        res
);
	import mnp_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_OFF  = 2'd1;
	localparam logic [1:0] MODE_ON   = 2'd2;

	// input stage
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state, also the result register
	logic               v_s2;
	logic [1:0]         mode_q;
	logic [1:0]         left_q;
	logic [BYTE_W-1:0]  held_q;
	logic [DATA_W-1:0]  first_q;
	logic [PITCH_W-1:0] pitch_q;
	logic               gate_q;
	logic               seen_q;

	logic               load_s2;
	logic               adv_s1;
	logic [1:0]         mode_n;
	logic [1:0]         left_n;
	logic [BYTE_W-1:0]  held_n;
	logic [PITCH_W-1:0] pitch_n;
	logic               gate_n;
	logic               seen_n;
	logic               store_first;
	logic [DATA_W-1:0]  note;
	logic [DATA_W-1:0]  vel;
	logic               note_match;

	assign load_s2  = !v_s2 || res.ready;
	assign adv_s1   = v_s1 && load_s2;
	assign rx.ready = !v_s1 || load_s2;

	assign note       = first_q;
	assign vel        = byte_s1[DATA_W-1:0];
	assign note_match = ({1'b0, note} == held_q);

	always_comb begin
		mode_n      = mode_q;
		left_n      = left_q;
		held_n      = held_q;
		pitch_n     = pitch_q;
		gate_n      = gate_q;
		seen_n      = seen_q;
		store_first = 1'b0;
		if (byte_s1[BYTE_W-1]) begin
			seen_n = 1'b1;
			unique case (byte_s1)
				ST_NOTE_OFF: begin
					mode_n = MODE_OFF;
					left_n = 2'd2;
				end
				ST_NOTE_ON: begin
					mode_n = MODE_ON;
					left_n = 2'd2;
				end
				ST_SENSE: begin
				end
				ST_STOP, ST_RESET: begin
					gate_n = 1'b0;
					mode_n = MODE_IDLE;
					left_n = 2'd0;
				end
				default: begin
					mode_n = MODE_IDLE;
					left_n = 2'd0;
				end
			endcase
		end else if (left_q == 2'd2) begin
			store_first = 1'b1;
			left_n      = 2'd1;
		end else if (left_q == 2'd1) begin
			// second data byte completes the message
			left_n = 2'd0;
			unique case (mode_q)
				MODE_OFF: begin
					left_n = 2'd2;
					if (note_match) begin
						gate_n = 1'b0;
						held_n = NO_NOTE;
					end
				end
				MODE_ON: begin
					left_n = 2'd2;
					if (vel == '0) begin
						if (note_match) begin
							gate_n = 1'b0;
							held_n = NO_NOTE;
						end
					end else begin
						gate_n  = 1'b1;
						pitch_n = NOTE_ROM[note];
						held_n  = {1'b0, note};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			mode_q  <= MODE_IDLE;
			left_q  <= 2'd0;
			held_q  <= NO_NOTE;
			pitch_q <= PITCH_RESET;
			gate_q  <= 1'b1;
			seen_q  <= 1'b0;
		end else begin
			if (load_s2) begin
				v_s2 <= v_s1;
			end
			// state moves only together with a new result
			if (adv_s1) begin
				mode_q  <= mode_n;
				left_q  <= left_n;
				held_q  <= held_n;
				pitch_q <= pitch_n;
				gate_q  <= gate_n;
				seen_q  <= seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && store_first) begin
			first_q <= byte_s1[DATA_W-1:0];
		end
	end

	assign res.valid       = v_s2;
	assign res.gate        = gate_q;
	assign res.pitch_count = pitch_q;
	assign res.midi_active = seen_q;

	a_mode_left: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) == (left_q == 2'd0))
		else $error("message mode and data count disagree");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q[BYTE_W-1] |-> (held_q == NO_NOTE))
		else $error("held note out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> ($stable(gate_q) && $stable(pitch_q) && $stable(held_q)
			&& $stable(mode_q) && $stable(left_q) && $stable(seen_q)))
		else $error("parser state changed under a stalled result");

	a_status_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && byte_s1[BYTE_W-1]) |=> (seen_q && v_s2))
		else $error("status byte did not mark midi active");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for midi_note_parser_unit. A predictor in the bench
// computes gate, pitch_count and midi_active for every accepted rx beat. Each
// res beat is checked against the oldest prediction. Directed cases come
// first, then random note messages and noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mnp_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_BYTES = 1130;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_OFF,
		MODE_ON
	} parse_mode_t;

	typedef struct packed {
		logic               gate;
		logic [PITCH_W-1:0] pitch_count;
		logic               midi_active;
	} note_state_t;

	logic clk;
	logic arst_n;

	mnp_byte_if rx_if();
	mnp_note_if res_if();

	midi_note_parser_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// predicted parser state
	parse_mode_t        parse_mode;
	logic [1:0]         bytes_due;
	logic [BYTE_W-1:0]  held_key;
	logic [DATA_W-1:0]  key_byte;
	logic [DATA_W-1:0]  vel_byte;
	logic [PITCH_W-1:0] cur_pitch;
	logic               gate_lit;
	logic               midi_seen;

	note_state_t pending_notes[$];

	int unsigned error_count;
	int unsigned bytes_sent;
	int unsigned idle_cycles;
	bit          src_calm;
	bit          snk_calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic int unsigned pause_len(input bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic void clear_note(input logic [DATA_W-1:0] key);
		if ({1'b0, key} == held_key) begin
			gate_lit = 1'b0;
			held_key = NO_NOTE;
		end
	endfunction

	// advance the predicted state by one byte and queue the state it leaves
	function automatic void track_byte(input logic [BYTE_W-1:0] b);
		if (b[7]) begin
			midi_seen = 1'b1;
			if (b == ST_NOTE_OFF) begin
				parse_mode = MODE_OFF;
				bytes_due = 2'd2;
			end else if (b == ST_NOTE_ON) begin
				parse_mode = MODE_ON;
				bytes_due = 2'd2;
			end else if (b != ST_SENSE) begin
				if (b == ST_STOP || b == ST_RESET)
					gate_lit = 1'b0;
				parse_mode = MODE_IDLE;
				bytes_due = 2'd0;
			end
		end else begin
			if (bytes_due != 2'd0) begin
				key_byte = vel_byte;
				vel_byte = b[DATA_W-1:0];
				bytes_due--;
			end
			// message complete: decode, then re-arm for running status
			if (bytes_due == 2'd0 && parse_mode != MODE_IDLE) begin
				if (parse_mode == MODE_OFF) begin
					clear_note(key_byte);
				end else if (vel_byte == '0) begin
					clear_note(key_byte);
				end else begin
					gate_lit = 1'b1;
					cur_pitch = NOTE_ROM[key_byte];
					held_key = {1'b0, key_byte};
				end
				bytes_due = 2'd2;
			end
		end
		pending_notes.push_back('{gate_lit, cur_pitch, midi_seen});
	endfunction

	always @(posedge clk) begin : monitor
		note_state_t want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rx_if.valid && rx_if.ready) begin
				track_byte(rx_if.rx_byte);
				moved = 1'b1;
			end
			if (res_if.valid && res_if.ready) begin
				moved = 1'b1;
				if (pending_notes.size() == 0) begin
					report($sformatf("res beat with nothing pending: gate=%0b pitch=%0d active=%0b",
						res_if.gate, res_if.pitch_count, res_if.midi_active));
				end else begin
					want = pending_notes.pop_front();
					if (res_if.gate !== want.gate)
						report($sformatf("gate: expected %0b, got %0b", want.gate, res_if.gate));
					if (res_if.pitch_count !== want.pitch_count)
						report($sformatf("pitch_count: expected %0d, got %0d",
							want.pitch_count, res_if.pitch_count));
					if (res_if.midi_active !== want.midi_active)
						report($sformatf("midi_active: expected %0b, got %0b",
							want.midi_active, res_if.midi_active));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("** midi_note_parser_unit: FAILED **");
				$finish;
			end
		end
	end

	// result side: stall a random number of cycles before taking each beat
	initial begin : res_drive
		int unsigned n;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pause_len(snk_calm);
			@(negedge clk);
			if (n != 0) begin
				res_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_if.valid);
		end
	end

	// valid stays high from one beat to the next when no gap is drawn
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned n;
		n = pause_len(src_calm);
		@(negedge clk);
		if (n != 0) begin
			rx_if.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		bytes_sent++;
	endtask

	task automatic test_idle_data;
		send_byte(8'h00);
		send_byte(8'h7F);
	endtask

	task automatic test_note_on_off;
		send_byte(ST_NOTE_ON);
		send_byte(8'h00);
		send_byte(8'h7F);
		// running status, highest note
		send_byte(8'h7F);
		send_byte(8'h01);
		// note-off for another note, then for the held one
		send_byte(ST_NOTE_OFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h40);
	endtask

	task automatic test_zero_velocity;
		send_byte(ST_NOTE_ON);
		send_byte(8'h3C);
		send_byte(8'h40);
		send_byte(8'h3D);
		send_byte(8'h00);
		send_byte(8'h3C);
		send_byte(8'h00);
	endtask

	task automatic test_system_status;
		send_byte(ST_NOTE_ON);
		send_byte(8'h45);
		// active sense inside a message keeps the parse going
		send_byte(ST_SENSE);
		send_byte(8'h20);
		send_byte(ST_STOP);
		send_byte(8'hF0);
		send_byte(ST_RESET);
	endtask

	function automatic logic [DATA_W-1:0] pick_key;
		if (held_key != NO_NOTE && $urandom_range(0, 2) == 0)
			return held_key[DATA_W-1:0];
		return DATA_W'($urandom_range(0, 127));
	endfunction

	task automatic test_random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned pairs;
		int unsigned kind;
		logic [DATA_W-1:0] vel;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 11) == 0) begin
				src_calm = ($urandom_range(0, 3) == 0);
				snk_calm = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < 75) begin
				// note messages, mostly with running status after the first
				if (parse_mode == MODE_IDLE || $urandom_range(0, 2) == 0)
					send_byte(($urandom_range(0, 99) < 65) ? ST_NOTE_ON : ST_NOTE_OFF);
				pairs = $urandom_range(1, 4);
				repeat (pairs) begin
					send_byte({1'b0, pick_key()});
					if ($urandom_range(0, 9) == 0)
						send_byte(ST_SENSE);
					vel = ($urandom_range(0, 3) == 0) ? '0 : DATA_W'($urandom_range(1, 127));
					send_byte({1'b0, vel});
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					kind = $urandom_range(0, 3);
					case (kind)
						0: send_byte($urandom_range(0, 1) ? ST_STOP : ST_RESET);
						1: send_byte(BYTE_W'($urandom_range(128, 255)));
						2: send_byte(BYTE_W'($urandom_range(0, 255)));
						default: send_byte(BYTE_W'($urandom_range(0, 127)));
					endcase
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		error_count = 0;
		bytes_sent = 0;
		idle_cycles = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		parse_mode = MODE_IDLE;
		bytes_due = 2'd0;
		held_key = NO_NOTE;
		key_byte = '0;
		vel_byte = '0;
		cur_pitch = PITCH_RESET;
		gate_lit = 1'b1;
		midi_seen = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_data();
		test_note_on_off();
		test_zero_velocity();
		test_system_status();
		test_random_traffic(RANDOM_BYTES);

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (pending_notes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** midi_note_parser_unit: PASSED **");
		end else begin
			$display("** midi_note_parser_unit: FAILED **");
		end
		$finish;
	end

endmodule
